@@ hdl/legik_pkg.sv @@
// shared types and constants for the leg inverse kinematics servo block
// item structs, arithmetic widths, cordic angle table and register indexes
// no dependencies
`default_nettype none

package legik_pkg;

	typedef struct packed {
		logic [1:0]         leg;
		logic signed [15:0] foot_x;
		logic signed [15:0] foot_z;
	} ik_in_t;

	typedef struct packed {
		logic [1:0]  leg_out;
		logic [11:0] hip_pulse;
		logic [11:0] knee_pulse;
		logic [7:0]  hip_degrees;
		logic [7:0]  knee_degrees;
		logic        reachable;
	} ik_out_t;

	// register file
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 64;
	localparam logic [CFG_IW-1:0] CFG_FEMUR = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_CALF  = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_SMIN  = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_SMAX  = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_TRIM  = 3'd4;

	localparam logic [15:0] FEMUR_RST = 16'd1792;
	localparam logic [15:0] CALF_RST  = 16'd1792;
	localparam logic [11:0] SMIN_RST  = 12'd150;
	localparam logic [11:0] SMAX_RST  = 12'd600;

	// integer square root
	localparam int SQ_W     = 62;
	localparam int SQ_STEPS = 31;
	localparam int SQ_RW    = 31;
	localparam logic [SQ_W-1:0] ARG_ONE = SQ_W'(1) << 60;

	// q2.30 divider
	localparam int DIV_NW    = 43;
	localparam int DIV_DW    = 42;
	localparam int DIV_STEPS = 30;
	localparam int Q_W       = 32;
	localparam logic signed [Q_W-1:0] ONE_Q30 = 32'sd1073741824;

	// cordic, angles in 2^-16 degree
	localparam int COR_W     = 34;
	localparam int ANG_W     = 26;
	localparam int COR_STEPS = 17;
	localparam logic signed [ANG_W-1:0] DEG_180 = 26'sd11796480;
	localparam logic signed [ANG_W-1:0] ATAN_TAB [COR_STEPS] = '{
		26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379,
		26'sd117304, 26'sd58666, 26'sd29335, 26'sd14668, 26'sd7334,
		26'sd3667, 26'sd1833, 26'sd917, 26'sd458, 26'sd229, 26'sd115, 26'sd57
	};

	// truncating divide by 180 as multiply and shift
	localparam logic [20:0] RECIP_180 = 21'd1491309;
	localparam int RECIP_SH = 28;

endpackage

`default_nettype wire

@@ hdl/legik_sqrt.sv @@
// pipelined integer square root, one result bit per stage
// depends on legik_pkg
`default_nettype none

module legik_sqrt import legik_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [SQ_W-1:0]  radicand,
	output logic                  out_valid,
	output logic [SQ_RW-1:0]      root
);

	logic            vld_s [SQ_STEPS];
	logic [SQ_W-1:0] rem_s [SQ_STEPS];
	logic [SQ_W-1:0] res_s [SQ_STEPS];

	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_st
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STEPS - 1 - i));
		logic            vin;
		logic [SQ_W-1:0] rem_in, res_in, trial, rem_nx, res_nx;

		always_comb begin
			if (i == 0) begin
				vin    = in_valid;
				rem_in = radicand;
				res_in = '0;
			end else begin
				vin    = vld_s[i-1];
				rem_in = rem_s[i-1];
				res_in = res_s[i-1];
			end
			trial = res_in + BIT;
			if (rem_in >= trial) begin
				rem_nx = rem_in - trial;
				res_nx = (res_in >> 1) + BIT;
			end else begin
				rem_nx = rem_in;
				res_nx = res_in >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else begin
				vld_s[i] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i] <= rem_nx;
			res_s[i] <= res_nx;
		end
	end

	assign out_valid = vld_s[SQ_STEPS-1];
	assign root      = res_s[SQ_STEPS-1][SQ_RW-1:0];

endmodule

`default_nettype wire

@@ hdl/legik_div.sv @@
// pipelined signed q2.30 divider with saturation to plus or minus one
// restoring division, one quotient bit per stage; depends on legik_pkg
`default_nettype none

module legik_div import legik_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	input  wire logic signed [DIV_NW-1:0] num,
	input  wire logic [DIV_DW-1:0]        den,
	output logic                          out_valid,
	output logic signed [Q_W-1:0]         quo,
	output logic                          sat
);

	localparam int N = DIV_STEPS + 1;

	logic              vld_s   [N];
	logic              neg_s   [N];
	logic              early_s [N];
	logic              sat_s   [N];
	logic [DIV_NW-1:0] rem_s   [N];
	logic [DIV_NW-1:0] den_s   [N];
	logic [DIV_STEPS-1:0] q_s  [N];

	logic [DIV_NW-1:0] mag, den_x;
	logic              sat0, one0;

	always_comb begin
		mag   = num[DIV_NW-1] ? DIV_NW'(-num) : DIV_NW'(num);
		den_x = DIV_NW'(den);
		sat0  = (den == '0) || (mag > den_x);
		one0  = (mag == den_x);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		neg_s[0]   <= num[DIV_NW-1];
		early_s[0] <= sat0 | one0;
		sat_s[0]   <= sat0;
		rem_s[0]   <= mag;
		den_s[0]   <= den_x;
		q_s[0]     <= '0;
	end

	for (genvar i = 1; i < N; i++) begin : g_st
		logic [DIV_NW-1:0] sh, rem_nx;
		logic              qb;

		always_comb begin
			sh = rem_s[i-1] << 1;
			qb = (sh >= den_s[i-1]);
			rem_nx = qb ? sh - den_s[i-1] : sh;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else begin
				vld_s[i] <= vld_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			neg_s[i]   <= neg_s[i-1];
			early_s[i] <= early_s[i-1];
			sat_s[i]   <= sat_s[i-1];
			den_s[i]   <= den_s[i-1];
			rem_s[i]   <= rem_nx;
			q_s[i]     <= {q_s[i-1][DIV_STEPS-2:0], qb};
		end
	end

	logic signed [Q_W-1:0] qv;

	always_comb begin
		qv = $signed({2'b00, q_s[N-1]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= vld_s[N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (early_s[N-1]) begin
			quo <= neg_s[N-1] ? -ONE_Q30 : ONE_Q30;
		end else begin
			quo <= neg_s[N-1] ? -qv : qv;
		end
		sat <= sat_s[N-1];
	end

endmodule

`default_nettype wire

@@ hdl/legik_cordic.sv @@
// pipelined vectoring cordic giving atan2(y, x) in 2^-16 degree
// one micro-rotation per stage; depends on legik_pkg
`default_nettype none

module legik_cordic import legik_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	input  wire logic signed [COR_W-1:0] y,
	input  wire logic signed [COR_W-1:0] x,
	output logic                         out_valid,
	output logic signed [ANG_W-1:0]      angle
);

	localparam int N = COR_STEPS + 1;

	logic                    vld_s  [N];
	logic                    fix_s  [N];
	logic signed [ANG_W-1:0] base_s [N];
	logic signed [ANG_W-1:0] ang_s  [N];
	logic signed [COR_W-1:0] x_s    [N];
	logic signed [COR_W-1:0] y_s    [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	// left half plane folded over, vector on the x axis resolved directly
	always_ff @(posedge clk) begin
		fix_s[0] <= (y == '0);
		ang_s[0] <= '0;
		if (y == '0) begin
			base_s[0] <= (x < 0) ? DEG_180 : '0;
			x_s[0]    <= x;
			y_s[0]    <= y;
		end else if (x < 0) begin
			base_s[0] <= (y >= 0) ? DEG_180 : -DEG_180;
			x_s[0]    <= -x;
			y_s[0]    <= -y;
		end else begin
			base_s[0] <= '0;
			x_s[0]    <= x;
			y_s[0]    <= y;
		end
	end

	for (genvar i = 0; i < COR_STEPS; i++) begin : g_st
		logic signed [COR_W-1:0] xn, yn;
		logic signed [ANG_W-1:0] an;

		always_comb begin
			if (y_s[i] > 0) begin
				xn = x_s[i] + (y_s[i] >>> i);
				yn = y_s[i] - (x_s[i] >>> i);
				an = ang_s[i] + ATAN_TAB[i];
			end else begin
				xn = x_s[i] - (y_s[i] >>> i);
				yn = y_s[i] + (x_s[i] >>> i);
				an = ang_s[i] - ATAN_TAB[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			fix_s[i+1]  <= fix_s[i];
			base_s[i+1] <= base_s[i];
			ang_s[i+1]  <= an;
			x_s[i+1]    <= xn;
			y_s[i+1]    <= yn;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= vld_s[N-1];
		end
	end

	always_ff @(posedge clk) begin
		angle <= fix_s[N-1] ? base_s[N-1] : base_s[N-1] + ang_s[N-1];
	end

endmodule

`default_nettype wire

@@ hdl/leg_ik_servo_pulse.sv @@
// top level: two-link leg inverse kinematics and servo pulse mapping
// depends on legik_pkg, legik_sqrt, legik_div, legik_cordic
//
// usage
//   command channel: an item (leg, foot_x, foot_z) is taken at each clock edge
//   with start high; busy is always low, so an item may follow every cycle
//   result channel: done is high for one cycle with the result item on result;
//   the receiver cannot hold it off and no storage waits on it
//   throughput one item per clock; each item passes in turn through the chain
//   square root (31 stages), q2.30 divider (32 stages), second square root
//   (31 stages) and cordic (19 stages)
//   configuration: cfg_we with cfg_index and cfg_data writes one register;
//   write only while no item is in flight
//   reset: arst_n clears all valid bits and loads register defaults
//   (segments 7 cm, pulse range 150 to 600, zero trims)
`default_nettype none

module leg_ik_servo_pulse import legik_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire ik_in_t            cmd,
	output logic                   done,
	output ik_out_t                result,
	input  wire logic              cfg_we,
	input  wire logic [CFG_IW-1:0] cfg_index,
	input  wire logic [CFG_DW-1:0] cfg_data
);

	typedef struct packed {
		logic [1:0]         leg;
		logic signed [15:0] x;
		logic signed [15:0] z;
		logic [31:0]        l2;
	} side_a_t;

	typedef struct packed {
		logic [1:0]         leg;
		logic signed [15:0] x;
		logic signed [15:0] z;
		logic               l2_zero;
	} side_b_t;

	typedef struct packed {
		logic [1:0]            leg;
		logic signed [15:0]    x;
		logic signed [15:0]    z;
		logic                  sat;
		logic signed [Q_W-1:0] hu;
		logic signed [Q_W-1:0] ku;
	} side_c_t;

	typedef struct packed {
		logic [1:0] leg;
		logic       sat;
	} side_d_t;

	// configuration registers
	logic [15:0] femur_q, calf_q;
	logic [11:0] smin_q, smax_q;
	logic [63:0] trim_q;
	logic [31:0] ff_q, cc_q;
	logic [32:0] fc2_q;
	logic signed [12:0] span_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			femur_q <= FEMUR_RST;
			calf_q  <= CALF_RST;
			smin_q  <= SMIN_RST;
			smax_q  <= SMAX_RST;
			trim_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FEMUR: femur_q <= cfg_data[15:0];
				CFG_CALF:  calf_q  <= cfg_data[15:0];
				CFG_SMIN:  smin_q  <= cfg_data[11:0];
				CFG_SMAX:  smax_q  <= cfg_data[11:0];
				CFG_TRIM:  trim_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		ff_q   <= 32'(femur_q) * 32'(femur_q);
		cc_q   <= 32'(calf_q) * 32'(calf_q);
		fc2_q  <= {32'(femur_q) * 32'(calf_q), 1'b0};
		span_q <= $signed({1'b0, smax_q}) - $signed({1'b0, smin_q});
	end

	assign busy = 1'b0;

	// s1: squares of the target
	logic vld_s1;
	logic [1:0] leg_s1;
	logic signed [15:0] x_s1, z_s1;
	logic signed [31:0] xx_s1, zz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		leg_s1 <= cmd.leg;
		x_s1   <= cmd.foot_x;
		z_s1   <= cmd.foot_z;
		xx_s1  <= cmd.foot_x * cmd.foot_x;
		zz_s1  <= cmd.foot_z * cmd.foot_z;
	end

	// s2: squared distance
	logic vld_s2;
	side_a_t sa_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		sa_s2.leg <= leg_s1;
		sa_s2.x   <= x_s1;
		sa_s2.z   <= z_s1;
		sa_s2.l2  <= xx_s1[31:0] + zz_s1[31:0];
	end

	// distance root
	logic sqa_vld;
	logic [SQ_RW-1:0] sqa_root;
	side_a_t sa_d [SQ_STEPS];

	legik_sqrt u_sqrt_len (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s2),
		.radicand (SQ_W'({sa_s2.l2, 16'h0000})),
		.out_valid(sqa_vld),
		.root     (sqa_root)
	);

	always_ff @(posedge clk) begin
		sa_d[0] <= sa_s2;
		for (int k = 1; k < SQ_STEPS; k++) begin
			sa_d[k] <= sa_d[k-1];
		end
	end

	// s3: law of cosines numerators and denominators
	logic vld_s3;
	side_b_t sb_s3;
	logic signed [DIV_NW-1:0] hnum_s3, knum_s3;
	logic [DIV_DW-1:0] hden_s3, kden_s3;
	side_a_t sa_o;
	logic signed [DIV_NW-1:0] ffx, ccx, l2x;

	always_comb begin
		sa_o = sa_d[SQ_STEPS-1];
		ffx  = $signed(DIV_NW'(ff_q));
		ccx  = $signed(DIV_NW'(cc_q));
		l2x  = $signed(DIV_NW'(sa_o.l2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= sqa_vld;
		end
	end

	always_ff @(posedge clk) begin
		sb_s3.leg     <= sa_o.leg;
		sb_s3.x       <= sa_o.x;
		sb_s3.z       <= sa_o.z;
		sb_s3.l2_zero <= (sa_o.l2 == '0);
		hnum_s3 <= (ffx + l2x - ccx) <<< 8;
		knum_s3 <= ffx + ccx - l2x;
		hden_s3 <= {1'b0, 40'(femur_q) * 40'(sqa_root[23:0]), 1'b0};
		kden_s3 <= DIV_DW'(fc2_q);
	end

	// cosines
	logic hd_vld, kd_vld, hd_sat, kd_sat;
	logic signed [Q_W-1:0] hd_q, kd_q;
	side_b_t sb_d [DIV_STEPS+2];

	legik_div u_div_hip (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s3),
		.num      (hnum_s3),
		.den      (hden_s3),
		.out_valid(hd_vld),
		.quo      (hd_q),
		.sat      (hd_sat)
	);

	legik_div u_div_knee (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s3),
		.num      (knum_s3),
		.den      (kden_s3),
		.out_valid(kd_vld),
		.quo      (kd_q),
		.sat      (kd_sat)
	);

	always_ff @(posedge clk) begin
		sb_d[0] <= sb_s3;
		for (int k = 1; k < DIV_STEPS + 2; k++) begin
			sb_d[k] <= sb_d[k-1];
		end
	end

	// s4: squares of the cosines
	logic vld_s4;
	side_c_t sc_s4;
	logic [SQ_W-1:0] hsq_s4, ksq_s4;
	logic [SQ_RW-1:0] hmag, kmag;
	side_b_t sb_o;

	always_comb begin
		sb_o = sb_d[DIV_STEPS+1];
		hmag = hd_q[Q_W-1] ? SQ_RW'(-hd_q) : SQ_RW'(hd_q);
		kmag = kd_q[Q_W-1] ? SQ_RW'(-kd_q) : SQ_RW'(kd_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= hd_vld & kd_vld;
		end
	end

	always_ff @(posedge clk) begin
		sc_s4.leg <= sb_o.leg;
		sc_s4.x   <= sb_o.x;
		sc_s4.z   <= sb_o.z;
		sc_s4.sat <= hd_sat | kd_sat | sb_o.l2_zero;
		sc_s4.hu  <= hd_q;
		sc_s4.ku  <= kd_q;
		hsq_s4    <= SQ_W'(hmag) * SQ_W'(hmag);
		ksq_s4    <= SQ_W'(kmag) * SQ_W'(kmag);
	end

	// s5: sine squared
	logic vld_s5;
	side_c_t sc_s5;
	logic [SQ_W-1:0] harg_s5, karg_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		sc_s5   <= sc_s4;
		harg_s5 <= ARG_ONE - hsq_s4;
		karg_s5 <= ARG_ONE - ksq_s4;
	end

	// sines
	logic hs_vld, ks_vld;
	logic [SQ_RW-1:0] hs_root, ks_root;
	side_c_t sc_d [SQ_STEPS];

	legik_sqrt u_sqrt_hip (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s5),
		.radicand (harg_s5),
		.out_valid(hs_vld),
		.root     (hs_root)
	);

	legik_sqrt u_sqrt_knee (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s5),
		.radicand (karg_s5),
		.out_valid(ks_vld),
		.root     (ks_root)
	);

	always_ff @(posedge clk) begin
		sc_d[0] <= sc_s5;
		for (int k = 1; k < SQ_STEPS; k++) begin
			sc_d[k] <= sc_d[k-1];
		end
	end

	// angles
	side_c_t sc_o;
	logic cv_vld;
	logic signed [COR_W-1:0] th_y, th_x;
	logic th_vld, ha_vld, ka_vld;
	logic signed [ANG_W-1:0] th_ang, ha_ang, ka_ang;
	side_d_t sd_d [COR_STEPS+2];

	always_comb begin
		sc_o   = sc_d[SQ_STEPS-1];
		cv_vld = hs_vld & ks_vld;
		th_y   = COR_W'($signed({sc_o.x, 14'h0000}));
		th_x   = COR_W'($signed({sc_o.z, 14'h0000}));
	end

	legik_cordic u_cor_theta (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cv_vld),
		.y        (th_y),
		.x        (th_x),
		.out_valid(th_vld),
		.angle    (th_ang)
	);

	legik_cordic u_cor_hip (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cv_vld),
		.y        ($signed(COR_W'(hs_root))),
		.x        (COR_W'(sc_o.hu)),
		.out_valid(ha_vld),
		.angle    (ha_ang)
	);

	legik_cordic u_cor_knee (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cv_vld),
		.y        ($signed(COR_W'(ks_root))),
		.x        (COR_W'(sc_o.ku)),
		.out_valid(ka_vld),
		.angle    (ka_ang)
	);

	always_ff @(posedge clk) begin
		sd_d[0].leg <= sc_o.leg;
		sd_d[0].sat <= sc_o.sat;
		for (int k = 1; k < COR_STEPS + 2; k++) begin
			sd_d[k] <= sd_d[k-1];
		end
	end

	// s6: hip angle sum
	logic vld_s6;
	side_d_t sd_s6;
	logic signed [26:0] hsum_s6, ksum_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= th_vld & ha_vld & ka_vld;
		end
	end

	always_ff @(posedge clk) begin
		sd_s6   <= sd_d[COR_STEPS+1];
		hsum_s6 <= 27'(th_ang) + 27'(ha_ang);
		ksum_s6 <= 27'(ka_ang);
	end

	// s7: round to whole degrees, halves away from zero
	function automatic logic signed [10:0] round_deg(input logic signed [26:0] v);
		logic [26:0] m;
		logic [26:0] r;
		m = v[26] ? 27'(-v) : 27'(v);
		r = (m + 27'd32768) >> 16;
		return v[26] ? -$signed(11'(r)) : $signed(11'(r));
	endfunction

	logic vld_s7;
	side_d_t sd_s7;
	logic signed [10:0] hr_s7, kr_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		sd_s7 <= sd_s6;
		hr_s7 <= round_deg(hsum_s6);
		kr_s7 <= round_deg(ksum_s6);
	end

	// s8: trim and clamp
	logic vld_s8;
	side_d_t sd_s8;
	logic [7:0] hdeg_s8, kdeg_s8;
	logic signed [11:0] ht, kt;

	function automatic logic [7:0] clamp_deg(input logic signed [11:0] v);
		if (v < 0) begin
			return 8'd0;
		end else if (v > 12'sd180) begin
			return 8'd180;
		end
		return 8'(v);
	endfunction

	always_comb begin
		ht = 12'(hr_s7) + 12'($signed(trim_q[{sd_s7.leg, 4'b0000} +: 8]));
		kt = 12'(kr_s7) + 12'($signed(trim_q[{sd_s7.leg, 4'b1000} +: 8]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		sd_s8   <= sd_s7;
		hdeg_s8 <= clamp_deg(ht);
		kdeg_s8 <= clamp_deg(kt);
	end

	// s9: scale by pulse span
	logic vld_s9;
	side_d_t sd_s9;
	logic [7:0] hdeg_s9, kdeg_s9;
	logic signed [20:0] hp_s9, kp_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else begin
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		sd_s9   <= sd_s8;
		hdeg_s9 <= hdeg_s8;
		kdeg_s9 <= kdeg_s8;
		hp_s9   <= 21'($signed({1'b0, hdeg_s8})) * 21'(span_q);
		kp_s9   <= 21'($signed({1'b0, kdeg_s8})) * 21'(span_q);
	end

	// s10: magnitude times reciprocal of 180
	logic vld_s10;
	side_d_t sd_s10;
	logic [7:0] hdeg_s10, kdeg_s10;
	logic hneg_s10, kneg_s10;
	logic [40:0] hm_s10, km_s10;
	logic [19:0] hpm, kpm;

	always_comb begin
		hpm = hp_s9[20] ? 20'(-hp_s9) : 20'(hp_s9);
		kpm = kp_s9[20] ? 20'(-kp_s9) : 20'(kp_s9);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else begin
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		sd_s10   <= sd_s9;
		hdeg_s10 <= hdeg_s9;
		kdeg_s10 <= kdeg_s9;
		hneg_s10 <= hp_s9[20];
		kneg_s10 <= kp_s9[20];
		hm_s10   <= 41'(hpm) * 41'(RECIP_180);
		km_s10   <= 41'(kpm) * 41'(RECIP_180);
	end

	// output register
	logic [11:0] hq, kq;
	logic done_q;
	ik_out_t result_q;

	always_comb begin
		hq = hm_s10[RECIP_SH +: 12];
		kq = km_s10[RECIP_SH +: 12];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s10;
		end
	end

	always_ff @(posedge clk) begin
		result_q.leg_out      <= sd_s10.leg;
		result_q.hip_pulse    <= smin_q + (hneg_s10 ? -hq : hq);
		result_q.knee_pulse   <= smin_q + (kneg_s10 ? -kq : kq);
		result_q.hip_degrees  <= hdeg_s10;
		result_q.knee_degrees <= kdeg_s10;
		result_q.reachable    <= ~sd_s10.sat;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire
